FILE: rtl/core/msg_pkg.sv
// ----------------------------------------------------------------------------
// msg_pkg
// Shared types and constants for the minimum group span block.
// ----------------------------------------------------------------------------
package msg_pkg;

  localparam int MaxValuesDef = 1024;
  localparam int ValueBitsDef = 16;
  localparam int GroupBits    = 11;
  localparam int SpanBits     = 16;

  typedef struct packed {
    logic [ValueBitsDef-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic [SpanBits-1:0] min_span;
    logic                no_group;
    logic                overflow;
  } out_item_t;

endpackage

FILE: rtl/core/min_spread_of_group_core.sv
// ----------------------------------------------------------------------------
// min_spread_of_group_core
// Collects a set of values and reports the smallest span of any group of
// group_size consecutive sorted values.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  in_data  (value, last)
// out       output     out_valid/out_ready out_data (min_span, no_group, overflow)
// cfg       input      cfg_we             cfg_data (group_size)
//
// Loading accepts one item per cycle while in_ready is high. After the last
// item the back end picks up the set record in the following cycle and sorts
// the set with an odd-even transposition sort over the store: N passes (one
// for two values), each compare stepping through S_RDA, S_RDB and S_CMP, plus
// S_WRB when the pair is swapped. The window scan then runs S_SPRE once and
// S_SRD and S_SCMP per window; S_OUT loads the result register once it is free.
// Reset is synchronous and clears control state and group_size to 1.
// Input stalls from the last item of a set until the back end is idle again;
// a result waiting to be taken only stalls once the next result is ready.
// ----------------------------------------------------------------------------
module min_spread_of_group_core #(
  parameter int MAX_VALUES = msg_pkg::MaxValuesDef,
  parameter int VALUE_BITS = msg_pkg::ValueBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  msg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msg_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [msg_pkg::GroupBits-1:0] cfg_data
);

  localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int CW = $clog2(MAX_VALUES + 1);

  logic [msg_pkg::GroupBits-1:0] group_size;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  set_valid;
  logic                  set_ready;
  logic [CW-1:0]         set_count;
  logic                  set_ovf;

  // The one configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= msg_pkg::GroupBits'(1);
    end else if (cfg_we) begin
      group_size <= cfg_data;
    end
  end

  msg_front #(.MAX_VALUES(MAX_VALUES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .wr_en, .wr_addr, .wr_data,
    .set_valid, .set_ready, .set_count, .set_ovf
  );

  msg_back #(.MAX_VALUES(MAX_VALUES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .group_size,
    .wr_en, .wr_addr, .wr_data,
    .set_valid, .set_ready, .set_count, .set_ovf,
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: rtl/core/msg_front.sv
// ----------------------------------------------------------------------------
// msg_front
// Accepts items, writes each value to the store while it has room and queues
// one set record (count and overflow flag) when the last item of a set arrives.
// ----------------------------------------------------------------------------
module msg_front #(
  parameter int MAX_VALUES = msg_pkg::MaxValuesDef,
  parameter int VALUE_BITS = msg_pkg::ValueBitsDef,
  parameter int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
  parameter int CW = $clog2(MAX_VALUES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  msg_pkg::in_item_t     in_data,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [VALUE_BITS-1:0] wr_data,
  output logic                  set_valid,
  input  logic                  set_ready,
  output logic [CW-1:0]         set_count,
  output logic                  set_ovf
);

  logic [CW-1:0] fill_count;
  logic          overflow_seen;
  logic          q_full;
  logic          take;
  logic          full;

  // The store is shared with the back end: a set may only be loaded once the
  // previous one has been handed over and finished.
  assign in_ready  = !q_full && set_ready;
  assign take      = in_valid && in_ready;
  assign full      = (fill_count == CW'(MAX_VALUES));
  assign wr_en     = take && !full;
  assign wr_addr   = fill_count[AW-1:0];
  assign wr_data   = VALUE_BITS'(in_data.value);
  assign set_valid = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      q_full        <= 1'b0;
    end else begin
      if (q_full && set_ready) begin
        q_full <= 1'b0;
      end
      if (take) begin
        if (in_data.last) begin
          set_count     <= full ? fill_count : fill_count + 1'b1;
          set_ovf       <= overflow_seen || full;
          q_full        <= 1'b1;
          fill_count    <= '0;
          overflow_seen <= 1'b0;
        end else if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/msg_back.sv
// ----------------------------------------------------------------------------
// msg_back
// Owns the value store. Sorts a set in place with an odd-even transposition
// sort, one compare-exchange at a time, then scans the windows; a set too small for a group skips both.
// ----------------------------------------------------------------------------
module msg_back #(
  parameter int MAX_VALUES = msg_pkg::MaxValuesDef,
  parameter int VALUE_BITS = msg_pkg::ValueBitsDef,
  parameter int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
  parameter int CW = $clog2(MAX_VALUES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [msg_pkg::GroupBits-1:0] group_size,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [VALUE_BITS-1:0]       wr_data,
  input  logic                        set_valid,
  output logic                        set_ready,
  input  logic [CW-1:0]               set_count,
  input  logic                        set_ovf,
  output logic                        out_valid,
  input  logic                        out_ready,
  output msg_pkg::out_item_t          out_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_RDA   = 9'b0_0000_0010,
    S_RDB   = 9'b0_0000_0100,
    S_CMP   = 9'b0_0000_1000,
    S_WRB   = 9'b0_0001_0000,
    S_SPRE  = 9'b0_0010_0000,
    S_SRD   = 9'b0_0100_0000,
    S_SCMP  = 9'b0_1000_0000,
    S_OUT   = 9'b1_0000_0000
  } state_t;

  localparam int GW = (CW > msg_pkg::GroupBits) ? CW : msg_pkg::GroupBits;

  logic [VALUE_BITS-1:0] mem [MAX_VALUES];
  logic [VALUE_BITS-1:0] rd_q;
  logic [VALUE_BITS-1:0] va;
  logic [AW-1:0]         rd_addr;
  logic                  mwe;
  logic [AW-1:0]         maddr;
  logic [VALUE_BITS-1:0] mdata;
  state_t                state;
  logic [CW-1:0]         n;
  logic [CW-1:0]         pass;
  logic [CW-1:0]         idx;
  logic [GW-1:0]         m;
  logic                  ovf;
  logic                  none;
  logic [VALUE_BITS-1:0] best;
  logic [GW:0]           hi_idx;
  logic [GW-1:0]         m_sel;
  logic                  none_sel;
  logic                  pair_next;
  logic                  last_pass;
  logic                  out_free;

  assign set_ready = (state == S_IDLE);

  // Store port: the front end writes while idle, the sorter swaps otherwise.
  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[maddr] <= mdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    mwe   = 1'b0;
    maddr = wr_addr;
    mdata = wr_data;
    if (state == S_IDLE) begin
      mwe = wr_en;
    end else if (state == S_CMP) begin
      mwe   = (va > rd_q);
      maddr = idx[AW-1:0];
      mdata = rd_q;
    end else if (state == S_WRB) begin
      mwe   = 1'b1;
      maddr = AW'(idx + 1'b1);
      mdata = va;
    end
  end

  assign hi_idx = (GW+1)'(idx) + (GW+1)'(m) - 1'b1;

  // A group size of zero counts as one.
  assign m_sel     = (group_size == '0) ? GW'(1) : GW'(group_size);
  assign none_sel  = m_sel > GW'(set_count);
  assign pair_next = (CW'(idx + 2'd3) < n);
  // A two-value set has no odd pairs, so its single even pass sorts it.
  assign last_pass = (pass + 1'b1 == n) || (n == CW'(2));
  assign out_free  = !out_valid || out_ready;

  // Sorting reads idx in S_RDA and idx+1 in S_RDB. The scan reads the lower
  // end in S_SPRE or in the previous window's S_SCMP, and the upper end in S_SRD.
  always_comb begin
    rd_addr = idx[AW-1:0];
    if (state == S_RDB || state == S_SCMP) begin
      rd_addr = AW'(idx + 1'b1);
    end else if (state == S_SRD) begin
      rd_addr = hi_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (set_valid) begin
            n    <= set_count;
            ovf  <= set_ovf;
            m    <= m_sel;
            none <= none_sel;
            pass <= '0;
            idx  <= '0;
            best <= '1;
            if (none_sel) begin
              state <= S_OUT;
            end else if (set_count > CW'(1)) begin
              state <= S_RDA;
            end else begin
              state <= S_SPRE;
            end
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          va    <= rd_q;
          state <= S_CMP;
        end
        S_CMP: begin
          if (va > rd_q) begin
            state <= S_WRB;
          end else if (pair_next) begin
            idx   <= idx + 2'd2;
            state <= S_RDA;
          end else if (last_pass) begin
            idx   <= '0;
            state <= S_SPRE;
          end else begin
            idx   <= (pass[0]) ? CW'(0) : CW'(1);
            pass  <= pass + 1'b1;
            state <= S_RDA;
          end
        end
        S_WRB: begin
          if (pair_next) begin
            idx   <= idx + 2'd2;
            state <= S_RDA;
          end else if (last_pass) begin
            idx   <= '0;
            state <= S_SPRE;
          end else begin
            idx   <= (pass[0]) ? CW'(0) : CW'(1);
            pass  <= pass + 1'b1;
            state <= S_RDA;
          end
        end
        // Window scan: the lower end of the first window is read here.
        S_SPRE: state <= S_SRD;
        S_SRD: begin
          va    <= rd_q;
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_q - va < best) begin
            best <= rd_q - va;
          end
          if ((GW+1)'(idx) + (GW+1)'(m) >= (GW+1)'(n)) begin
            state <= S_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SRD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: a waiting result does not hold the back end, which may
  // start on the next set until that one's result is ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid         <= 1'b1;
      out_data.min_span <= none ? '0 : msg_pkg::SpanBits'(best);
      out_data.no_group <= none;
      out_data.overflow <= ovf;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/min_spread_of_group_core_tb.sv
// ----------------------------------------------------------------------------
// min_spread_of_group_core_tb
// Self-checking bench for the minimum group span block. Sets of values are
// queued by a stimulus process and sent by a clocked driver with random gaps.
// A predictor sorts each accepted set that holds a group, scans its windows,
// and a clocked monitor compares every result item with the oldest predicted one.
// ----------------------------------------------------------------------------
module min_spread_of_group_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth = 1024;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  msg_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  msg_pkg::out_item_t out_data;
  logic cfg_we;
  logic [msg_pkg::GroupBits-1:0] cfg_data;

  min_spread_of_group_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // Items waiting to be sent, and spans predicted but not yet seen.
  msg_pkg::in_item_t  send_q[$];
  msg_pkg::out_item_t span_q[$];

  // The predictor's own copy of the block state.
  logic [15:0] set_vals[StoreDepth];
  int unsigned set_fill;
  bit set_ovf;
  logic [msg_pkg::GroupBits-1:0] group_reg;

  bit quiet;
  bit failed;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Add one value to the set, or flag overflow once full; on the last mark,
  // sort the values and find the narrowest window of group_reg consecutive ones.
  task automatic predict_item(input msg_pkg::in_item_t it);
    msg_pkg::out_item_t r;
    int unsigned m;
    logic [15:0] key;
    int j;
    int unsigned best;
    if (set_fill < StoreDepth) begin
      set_vals[set_fill] = it.value;
      set_fill++;
    end else begin
      set_ovf = 1'b1;
    end
    if (it.last) begin
      // A group size of zero behaves like a group size of one.
      m = (group_reg == 0) ? 1 : group_reg;
      r.overflow = set_ovf;
      r.no_group = (m > set_fill);
      r.min_span = '0;
      if (!r.no_group) begin
        for (int i = 1; i < set_fill; i++) begin
          key = set_vals[i];
          j = i - 1;
          while (j >= 0 && set_vals[j] > key) begin
            set_vals[j + 1] = set_vals[j];
            j--;
          end
          set_vals[j + 1] = key;
        end
        best = 32'hFFFF_FFFF;
        for (int i = 0; i + m <= set_fill; i++) begin
          if (set_vals[i + m - 1] - set_vals[i] < best) begin
            best = set_vals[i + m - 1] - set_vals[i];
          end
        end
        r.min_span = best[15:0];
      end
      span_q.push_back(r);
      set_fill = 0;
      set_ovf = 1'b0;
    end
  endtask

  // Driver: predicts each item as it is accepted, then loads the next one
  // unless a random gap is running. Valid stays up until acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          in_data <= send_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure bursts, and a field-by-field compare.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (span_q.size() == 0) begin
          $display("%0t: result with none expected: span %0d no_group %0b overflow %0b",
                   $time, out_data.min_span, out_data.no_group, out_data.overflow);
          failed = 1'b1;
        end else begin
          msg_pkg::out_item_t want;
          want = span_q.pop_front();
          if (want.min_span !== out_data.min_span) begin
            $display("%0t: min_span expected %0d actual %0d",
                     $time, want.min_span, out_data.min_span);
            failed = 1'b1;
          end
          if (want.no_group !== out_data.no_group) begin
            $display("%0t: no_group expected %0b actual %0b",
                     $time, want.no_group, out_data.no_group);
            failed = 1'b1;
          end
          if (want.overflow !== out_data.overflow) begin
            $display("%0t: overflow expected %0b actual %0b",
                     $time, want.overflow, out_data.overflow);
            failed = 1'b1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) begin
          recv_gap <= $urandom_range(1, 8);
        end
      end
    end
  end

  // Pick a value: full range, a tight cluster (small spans), or an extreme.
  function automatic logic [15:0] pick_value(input int unsigned mode, input logic [15:0] base);
    case (mode)
      0: begin
        return 16'($urandom_range(0, 16'hFFFF));
      end
      1: begin
        return base + 16'($urandom_range(0, 63));
      end
      default: begin
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
    endcase
  endfunction

  // Queue one set of n values; only the final one carries the last mark.
  task automatic queue_set(input int unsigned n, input int unsigned mode);
    msg_pkg::in_item_t it;
    logic [15:0] base;
    base = 16'($urandom_range(0, 16'hFFFF));
    for (int unsigned i = 0; i < n; i++) begin
      it.value = pick_value(mode, base);
      it.last = (i == n - 1);
      send_q.push_back(it);
      sent++;
    end
  endtask

  // Let every queued item go out and every result come back, so the block
  // is idle. This is also the point where the sender holds off.
  task automatic drain;
    while (send_q.size() > 0 || in_valid || span_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_group(input logic [msg_pkg::GroupBits-1:0] g);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= g;
    group_reg = g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    failed = 1'b0;
    set_fill = 0;
    set_ovf = 1'b0;
    sent = 0;
    group_reg = msg_pkg::GroupBits'(1);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the group size left at its reset value of one.
    queue_set(1, 2);
    queue_set(2, 2);
    queue_set(3, 1);
    // Group size zero acts as one.
    write_group(msg_pkg::GroupBits'(0));
    queue_set(4, 0);
    // Too few values for a group, then exactly enough.
    write_group(msg_pkg::GroupBits'(5));
    queue_set(4, 0);
    queue_set(5, 2);
    // Group size above the store's capacity never finds a window.
    write_group(11'h7FF);
    queue_set(3, 0);
    // Store full: the extra values are dropped and flagged; one full window.
    write_group(msg_pkg::GroupBits'(StoreDepth));
    queue_set(StoreDepth + 6, 0);
    write_group(msg_pkg::GroupBits'(2));
    queue_set(1, 0);

    // Random part: sets of at most 40 values so the quadratic sort stays quick.
    while (sent < 1500) begin
      int unsigned n;
      if (sent > 1300) begin
        quiet = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        int unsigned g;
        case ($urandom_range(0, 5))
          0: g = 0;
          1: g = 11'h7FF;
          2: g = $urandom_range(0, 11'h7FF);
          default: g = $urandom_range(1, 12);
        endcase
        write_group(g[msg_pkg::GroupBits-1:0]);
      end
      n = $urandom_range(1, 40);
      queue_set(n, $urandom_range(0, 2));
      // Keep the backlog short so config writes keep landing between sets.
      while (send_q.size() > 60) begin
        @(posedge clk);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("min_spread_of_group_core: match");
    end else begin
      $display("min_spread_of_group_core: mismatch");
    end
    $finish;
  end

  // Timeout with room for the slow full-store sort; it reports a mismatch and stops.
  initial begin
    #100_000_000;
    $display("min_spread_of_group_core: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/msg_pkg.sv
rtl/core/msg_front.sv
rtl/core/msg_back.sv
rtl/core/min_spread_of_group_core.sv
tb/min_spread_of_group_core_tb.sv
